// ----- sv/bbec_pkg.sv -----
// bbec_pkg: shared constants and types for the box blur with edge clamp.
// No dependencies; every other file of the block imports it.
`default_nettype none
package bbec_pkg;

   localparam int PIX_W   = 8;    // one channel sample
   localparam int LANES   = 4;    // channels carried per pixel
   localparam int CRD_W   = 13;   // coordinate math, covers any legal width
   localparam int ROW_W   = 11;   // row counters, up to 1024
   localparam int REG_W   = 11;   // widest config register
   localparam int IDX_W   = 2;    // config register index
   localparam int SUM_W   = 18;   // window sum, up to 15*15*255
   localparam int DIV_W   = 10;   // window count, up to 15*15
   localparam int QUO_W   = 8;    // one mean per channel

   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
   localparam logic [IDX_W-1:0] REG_RADIUS        = 2'd3;

   // one stage of the divider row
   typedef struct packed {
      logic                             valid;
      logic [DIV_W-1:0]                 div;
      logic [LANES-1:0][SUM_W-1:0]      rem;
      logic [LANES-1:0][QUO_W-1:0]      quo;
   } link_type;

endpackage
`default_nettype wire

// ----- sv/bbec_req_if.sv -----
// bbec_req_if: input pixel channel (valid/ready plus flush and samples).
// Depends on bbec_pkg.
`default_nettype none
interface bbec_req_if
   import bbec_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             flush;
   logic [PIX_W-1:0] pixel_c0;
   logic [PIX_W-1:0] pixel_c1;
   logic [PIX_W-1:0] pixel_c2;
   logic [PIX_W-1:0] pixel_c3;

   modport source (output valid, flush, pixel_c0, pixel_c1, pixel_c2, pixel_c3,
                   input ready);
   modport sink   (input valid, flush, pixel_c0, pixel_c1, pixel_c2, pixel_c3,
                   output ready);
endinterface
`default_nettype wire

// ----- sv/bbec_rsp_if.sv -----
// bbec_rsp_if: output pixel channel (valid/ready plus means and position).
// Depends on bbec_pkg.
`default_nettype none
interface bbec_rsp_if
   import bbec_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_c0;
   logic [PIX_W-1:0] out_c1;
   logic [PIX_W-1:0] out_c2;
   logic [PIX_W-1:0] out_c3;
   logic [9:0]       out_x;
   logic [9:0]       out_y;
   logic             frame_last;

   modport source (output valid, out_c0, out_c1, out_c2, out_c3, out_x, out_y,
                   frame_last, input ready);
   modport sink   (input valid, out_c0, out_c1, out_c2, out_c3, out_x, out_y,
                   frame_last, output ready);
endinterface
`default_nettype wire

// ----- sv/bbec_div_cell.sv -----
// bbec_div_cell: one restoring-division step, decides quotient bit SHIFT
// for all lanes and hands the remainder on. Depends on bbec_pkg.
`default_nettype none
module bbec_div_cell
   import bbec_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire link_type link_i,
   output link_type      link_o
);

   localparam int CMP_W = SUM_W + QUO_W;

   logic                  valid_ff;
   link_type              data_ff, data_in;
   logic [CMP_W-1:0]      step;
   logic [CMP_W-1:0]      rem_x;

   assign step = CMP_W'(link_i.div) << SHIFT;

   always_comb begin
      data_in = link_i;
      rem_x   = '0;
      for (int l = 0; l < LANES; l++) begin
         rem_x = CMP_W'(link_i.rem[l]);
         if (rem_x >= step) begin
            data_in.rem[l]        = SUM_W'(rem_x - step);
            data_in.quo[l][SHIFT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= link_i.valid;
      end
      data_ff <= data_in;
   end

   always_comb begin
      link_o       = data_ff;
      link_o.valid = valid_ff;
   end

endmodule
`default_nettype wire

// ----- sv/bbec_div_chain.sv -----
// bbec_div_chain: row of QUO_W division cells, most significant bit first.
// Depends on bbec_pkg and bbec_div_cell.
`default_nettype none
module bbec_div_chain
   import bbec_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire link_type link_i,
   output link_type      link_o
);

   link_type links [QUO_W+1];

   assign links[0] = link_i;

   for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      bbec_div_cell #(.SHIFT(QUO_W - 1 - k)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .link_i (links[k]),
         .link_o (links[k+1])
      );
   end

   assign link_o = links[QUO_W];

endmodule
`default_nettype wire

// ----- sv/box_blur_edge_clamp.sv -----
// box_blur_edge_clamp: streaming box blur with replicated border, top level.
// Depends on bbec_pkg, bbec_req_if, bbec_rsp_if, bbec_div_chain.
//
//  channel   dir  handshake          payload
//  req_bus   in   valid/ready        flush, pixel_c0..pixel_c3
//  rsp_bus   out  valid/ready        out_c0..out_c3, out_x, out_y, frame_last
//  csr_*     in   csr_wr_en          csr_index, csr_wdata
//
// Flow: a beat that yields no output passes ST_IDLE and ST_CHECK; one that yields
// an output then passes ST_SCAN, paced by the single line store read port (one
// window pixel per cycle), ST_DRAIN and ST_WAIT, which waits on the divider row.
// Reset: control and counters clear at once; line store needs no clearing.
// Stalls: a finished result waits in the output register while the next
// beat is taken; a new division is only started once that register is free.
`default_nettype none
module box_blur_edge_clamp
   import bbec_pkg::*;
#(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_RADIUS   = 7,
   parameter int MAX_CHANNELS = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   bbec_req_if.sink              req_bus,
   bbec_rsp_if.source            rsp_bus,
   input  wire logic             csr_wr_en,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0] csr_wdata
);

   localparam int RING = 2 * MAX_RADIUS + 2;   // rows held in the store
   localparam int RGW  = $clog2(RING);
   localparam int CIW  = $clog2(MAX_WIDTH);
   localparam int OW   = $clog2(2 * MAX_RADIUS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;

   // config
   logic [REG_W-1:0] width_ff, height_ff;
   logic [2:0]       chans_ff, radius_ff;

   // frame counters
   logic [CIW-1:0]   in_col_ff, out_col_ff;
   logic [ROW_W-1:0] in_row_ff, out_row_ff;
   logic [RGW-1:0]   in_ring_ff, out_ring_ff;

   // scan
   logic [2:0]       state_ff;
   logic [OW-1:0]    dx_ff, dy_ff;
   logic [CRD_W-1:0] yy_ff;
   logic [RGW-1:0]   ry_ff;
   logic             rd_en_ff;
   logic [31:0]      rd_data_ff;
   logic [LANES-1:0][SUM_W-1:0] sum_ff;
   logic [DIV_W-1:0] count_ff;

   // pending output position
   logic [9:0]       px_ff, py_ff;
   logic             plast_ff;

   // output register
   logic             rsp_valid_ff;
   logic [LANES-1:0][PIX_W-1:0] rsp_c_ff;
   logic [9:0]       rsp_x_ff, rsp_y_ff;
   logic             rsp_last_ff;

   logic [31:0]      line_mem [RING][MAX_WIDTH];

   // effective settings
   logic [CRD_W-1:0] w, h, r, nch;
   always_comb begin
      w = (width_ff == '0) ? CRD_W'(1) :
          (CRD_W'(width_ff) > CRD_W'(MAX_WIDTH)) ? CRD_W'(MAX_WIDTH) : CRD_W'(width_ff);
      h = (height_ff == '0) ? CRD_W'(1) :
          (CRD_W'(height_ff) > CRD_W'(1024)) ? CRD_W'(1024) : CRD_W'(height_ff);
      r = (CRD_W'(radius_ff) > CRD_W'(MAX_RADIUS)) ? CRD_W'(MAX_RADIUS)
                                                   : CRD_W'(radius_ff);
      nch = (chans_ff == '0) ? CRD_W'(1) :
            (CRD_W'(chans_ff) > CRD_W'(MAX_CHANNELS)) ? CRD_W'(MAX_CHANNELS)
                                                     : CRD_W'(chans_ff);
   end

   logic [CRD_W-1:0] in_col, in_row, out_col, out_row;
   assign in_col  = CRD_W'(in_col_ff);
   assign in_row  = CRD_W'(in_row_ff);
   assign out_col = CRD_W'(out_col_ff);
   assign out_row = CRD_W'(out_row_ff);

   // an output is due once its whole window has arrived
   logic [CRD_W-1:0] need_row, need_col;
   logic             due;
   always_comb begin
      need_row = (out_row + r > h - 1) ? h - 1 : out_row + r;
      need_col = (out_col + r > w - 1) ? w - 1 : out_col + r;
      due = (in_row >= h) || (in_row > need_row) ||
            (in_row == need_row && in_col > need_col);
   end

   // window addressing, clamped to the image
   logic [CRD_W-1:0] tx, xx, ty, yy_next, yy_first, back;
   logic [RGW-1:0]   ry_first;
   logic [CRD_W-1:0] two_r;
   logic             last_x, last_y;
   always_comb begin
      two_r = r << 1;
      tx = out_col + CRD_W'(dx_ff);
      xx = (tx < r) ? '0 : ((tx - r > w - 1) ? w - 1 : tx - r);
      ty = out_row + CRD_W'(dy_ff) + CRD_W'(1);
      yy_next = (ty < r) ? '0 : ((ty - r > h - 1) ? h - 1 : ty - r);
      yy_first = (out_row < r) ? '0 : out_row - r;
      back = out_row - yy_first;
      ry_first = (CRD_W'(out_ring_ff) >= back) ? RGW'(CRD_W'(out_ring_ff) - back)
                                               : RGW'(CRD_W'(out_ring_ff) + CRD_W'(RING) - back);
      last_x = (CRD_W'(dx_ff) == two_r);
      last_y = (CRD_W'(dy_ff) == two_r);
   end

   logic [CRD_W-1:0] side;
   assign side = two_r + CRD_W'(1);

   // handshake
   logic req_fire, rsp_fire, pix_write, launch;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign pix_write = req_fire && !req_bus.flush && (in_row < h);
   assign rsp_fire  = rsp_valid_ff && rsp_bus.ready;
   assign launch    = (state_ff == ST_DRAIN) && !rd_en_ff && !rsp_valid_ff;

   logic frame_end;
   assign frame_end = (out_col == w - 1) && (out_row == h - 1);

   // divider row
   link_type div_in, div_out;
   always_comb begin
      div_in       = '0;
      div_in.valid = launch;
      div_in.div   = count_ff;
      div_in.rem   = sum_ff;
   end

   bbec_div_chain u_div (
      .clock  (clock),
      .reset  (reset),
      .link_i (div_in),
      .link_o (div_out)
   );

   // line store
   always_ff @(posedge clock) begin
      if (pix_write) begin
         line_mem[in_ring_ff][in_col_ff] <= {req_bus.pixel_c3, req_bus.pixel_c2,
                                             req_bus.pixel_c1, req_bus.pixel_c0};
      end
      if (state_ff == ST_SCAN) begin
         rd_data_ff <= line_mem[ry_ff][CIW'(xx)];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= REG_W'(1024);
         height_ff    <= REG_W'(1024);
         chans_ff     <= 3'd3;
         radius_ff    <= 3'd1;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_ring_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_ring_ff  <= '0;
         state_ff     <= ST_IDLE;
         rd_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_en_ff <= (state_ff == ST_SCAN);

         if (pix_write) begin
            if (in_col + 1 == w) begin
               in_col_ff  <= '0;
               in_row_ff  <= in_row_ff + 1'b1;
               in_ring_ff <= (in_ring_ff == RGW'(RING - 1)) ? '0 : in_ring_ff + 1'b1;
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (due) begin
                  state_ff <= ST_SCAN;
                  dx_ff    <= '0;
                  dy_ff    <= '0;
                  yy_ff    <= yy_first;
                  ry_ff    <= ry_first;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SCAN: begin
               if (last_x) begin
                  dx_ff <= '0;
                  dy_ff <= dy_ff + 1'b1;
                  if (yy_next != yy_ff) begin
                     yy_ff <= yy_next;
                     ry_ff <= (ry_ff == RGW'(RING - 1)) ? '0 : ry_ff + 1'b1;
                  end
                  if (last_y) state_ff <= ST_DRAIN;
               end else begin
                  dx_ff <= dx_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (launch) begin
                  state_ff <= ST_WAIT;
                  if (frame_end) begin
                     in_col_ff   <= '0;
                     in_row_ff   <= '0;
                     in_ring_ff  <= '0;
                     out_col_ff  <= '0;
                     out_row_ff  <= '0;
                     out_ring_ff <= '0;
                  end else if (out_col + 1 == w) begin
                     out_col_ff  <= '0;
                     out_row_ff  <= out_row_ff + 1'b1;
                     out_ring_ff <= (out_ring_ff == RGW'(RING - 1)) ? '0
                                                                    : out_ring_ff + 1'b1;
                  end else begin
                     out_col_ff <= out_col_ff + 1'b1;
                  end
               end
            end
            ST_WAIT: begin
               if (div_out.valid) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (div_out.valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end

         // register writes restart the frame
         if (csr_wr_en) begin
            case (csr_index)
               REG_IMAGE_WIDTH:   width_ff  <= csr_wdata;
               REG_IMAGE_HEIGHT:  height_ff <= csr_wdata;
               REG_CHANNEL_COUNT: chans_ff  <= csr_wdata[2:0];
               REG_RADIUS:        radius_ff <= csr_wdata[2:0];
               default:           width_ff  <= width_ff;
            endcase
            in_col_ff   <= '0;
            in_row_ff   <= '0;
            in_ring_ff  <= '0;
            out_col_ff  <= '0;
            out_row_ff  <= '0;
            out_ring_ff <= '0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         sum_ff   <= '0;
         count_ff <= DIV_W'(side * side);
      end else if (rd_en_ff) begin
         for (int l = 0; l < LANES; l++) begin
            sum_ff[l] <= sum_ff[l] + SUM_W'(rd_data_ff[PIX_W*l +: PIX_W]);
         end
      end
      if (launch) begin
         px_ff    <= out_col_ff[9:0];
         py_ff    <= out_row_ff[9:0];
         plast_ff <= frame_end;
      end
      if (div_out.valid) begin
         for (int l = 0; l < LANES; l++) begin
            rsp_c_ff[l] <= (CRD_W'(l) < nch) ? div_out.quo[l] : '0;
         end
         rsp_x_ff    <= px_ff;
         rsp_y_ff    <= py_ff;
         rsp_last_ff <= plast_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_c0     = rsp_c_ff[0];
   assign rsp_bus.out_c1     = rsp_c_ff[1];
   assign rsp_bus.out_c2     = rsp_c_ff[2];
   assign rsp_bus.out_c3     = rsp_c_ff[3];
   assign rsp_bus.out_x      = rsp_x_ff;
   assign rsp_bus.out_y      = rsp_y_ff;
   assign rsp_bus.frame_last = rsp_last_ff;

endmodule
`default_nettype wire
